// File: design/assert_macros.svh
// Assertion macros shared by the checker RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that prop holds at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Check that cond never holds at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// File: design/nsc_pkg.sv
// Shared types, constants and helpers for the NMEA sentence checker.
// No dependencies; imported by every checker module.
package nsc_pkg;

   localparam int NSC_MAX_LINE_CHARS = 255;
   localparam int QUEUE_DEPTH        = 2;
   localparam int NUM_KINDS          = 5;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_NUL    = 8'h00;

   typedef enum logic [2:0] {
      STATUS_MALFORMED = 3'd0,
      STATUS_CSUM_ERR  = 3'd1,
      STATUS_GGA       = 3'd2,
      STATUS_RMC       = 3'd3,
      STATUS_GSA       = 3'd4,
      STATUS_GSV       = 3'd5,
      STATUS_VTG       = 3'd6,
      STATUS_OTHER     = 3'd7
   } status_type;

   // Sentence kind names, three characters each, first character in the top byte.
   localparam logic [23:0] KIND_NAMES [NUM_KINDS] = '{"GGA", "RMC", "GSA", "GSV", "VTG"};
   localparam status_type KIND_STATUS [NUM_KINDS] =
      '{STATUS_GGA, STATUS_RMC, STATUS_GSA, STATUS_GSV, STATUS_VTG};

   // One finished line, handed from the front end to the counter stage.
   typedef struct packed {
      status_type  status;
      logic [7:0]  line_length;
      logic [7:0]  computed_sum;
      logic [7:0]  expected_sum;
   } line_type;

   // Return {is_hex, digit value}.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'b0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

// File: design/nmea_sentence_checker.sv
// NMEA sentence checker: a byte per unstalled cycle in, one result per finished line out.
// A line end is registered into the line queue and then into the result register on rsp_*.
// Throughput: one byte each cycle unless stalled; results drain at one per cycle unless
// rsp_stall is high, through a two-entry line queue; req_stall rises only while that queue is full.
// Reset (synchronous, active high) clears line state, queue and all counters.
// Depends on nsc_pkg, nsc_front, nsc_queue and nsc_back.
module nmea_sentence_checker #(
   parameter int MAX_LINE_CHARS = nsc_pkg::NSC_MAX_LINE_CHARS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_line_length,
   output logic [7:0]  rsp_computed_sum,
   output logic [7:0]  rsp_expected_sum,
   output logic [31:0] rsp_total_lines,
   output logic [31:0] rsp_error_total,
   output logic [31:0] rsp_kind_total
);
   import nsc_pkg::*;

   // Front end to queue: a classified line on every non-empty line end.
   logic     push;
   line_type push_line;
   // Queue to back end.
   logic     queue_full;
   logic     queue_not_empty;
   logic     pop;
   line_type pop_line;

   // Track the current line and classify it when CR or LF arrives; stall the
   // request channel only when the queue has no room.
   nsc_front #(
      .MAX_LINE_CHARS(MAX_LINE_CHARS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .queue_full  (queue_full),
      .req_stall   (req_stall),
      .push        (push),
      .push_line   (push_line)
   );

   // Hold finished lines so the byte stream keeps flowing while a result waits.
   nsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_line (push_line),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .pop_line  (pop_line)
   );

   // Advance the running counters and present each line as one result.
   nsc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .not_empty        (queue_not_empty),
      .pop_line         (pop_line),
      .pop              (pop),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_line_length  (rsp_line_length),
      .rsp_computed_sum (rsp_computed_sum),
      .rsp_expected_sum (rsp_expected_sum),
      .rsp_total_lines  (rsp_total_lines),
      .rsp_error_total  (rsp_error_total),
      .rsp_kind_total   (rsp_kind_total)
   );

endmodule

// File: design/nsc_front.sv
// Front end: takes receiver bytes, tracks one line and classifies it at line end.
// Depends on nsc_pkg.
module nsc_front #(
   parameter int MAX_LINE_CHARS = nsc_pkg::NSC_MAX_LINE_CHARS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [7:0]        req_rx_byte,
   input  logic              queue_full,
   output logic              req_stall,
   output logic              push,
   output nsc_pkg::line_type push_line
);
   import nsc_pkg::*;

   localparam logic [7:0] MAX_CHARS = 8'(MAX_LINE_CHARS);

   logic [7:0]  char_count_ff, char_count_in;
   logic        lead_dollar_ff, lead_dollar_in;
   logic        zero_seen_ff, zero_seen_in;
   logic        star_seen_ff, star_seen_in;
   logic        star_early_ff, star_early_in;
   logic [7:0]  xor_ff, xor_in;
   logic [7:0]  hex_ff [2];
   logic [7:0]  hex_in [2];
   logic [1:0]  after_star_ff, after_star_in;
   logic [7:0]  kind_ff [3];
   logic [7:0]  kind_in [3];

   logic       accept;
   logic       is_eol;
   logic [4:0] hi_digit;
   logic [4:0] lo_digit;
   logic [7:0] expected;
   status_type kind_status;
   line_type   line;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign is_eol    = (req_rx_byte == CHAR_LF) || (req_rx_byte == CHAR_CR);
   assign push      = accept && is_eol && (char_count_ff != 8'd0);
   assign push_line = line;

   // Classify the line held in the state registers.
   always_comb begin
      hi_digit = hex_digit(hex_ff[0]);
      lo_digit = hex_digit(hex_ff[1]);
      if (!hi_digit[4]) begin
         expected = 8'd0;
      end else if (!lo_digit[4]) begin
         expected = {4'd0, hi_digit[3:0]};
      end else begin
         expected = {hi_digit[3:0], lo_digit[3:0]};
      end
      kind_status = STATUS_OTHER;
      for (int k = NUM_KINDS - 1; k >= 0; k--) begin
         if ({kind_ff[0], kind_ff[1], kind_ff[2]} == KIND_NAMES[k]) begin
            kind_status = KIND_STATUS[k];
         end
      end
      line.line_length = char_count_ff;
      if (!lead_dollar_ff || !star_seen_ff) begin
         line.status       = STATUS_MALFORMED;
         line.computed_sum = 8'd0;
         line.expected_sum = 8'd0;
      end else begin
         line.computed_sum = xor_ff;
         line.expected_sum = expected;
         if (star_early_ff || (after_star_ff != 2'd2) || (xor_ff != expected)) begin
            line.status = STATUS_CSUM_ERR;
         end else begin
            line.status = kind_status;
         end
      end
   end

   // Per-byte line tracking.
   always_comb begin
      char_count_in  = char_count_ff;
      lead_dollar_in = lead_dollar_ff;
      zero_seen_in   = zero_seen_ff;
      star_seen_in   = star_seen_ff;
      star_early_in  = star_early_ff;
      xor_in         = xor_ff;
      hex_in         = hex_ff;
      after_star_in  = after_star_ff;
      kind_in        = kind_ff;
      if (accept) begin
         if (is_eol) begin
            char_count_in  = 8'd0;
            lead_dollar_in = 1'b0;
            zero_seen_in   = 1'b0;
            star_seen_in   = 1'b0;
            star_early_in  = 1'b0;
            xor_in         = 8'd0;
            hex_in         = '{8'd0, 8'd0};
            after_star_in  = 2'd0;
            kind_in        = '{8'd0, 8'd0, 8'd0};
         end else if (char_count_ff < MAX_CHARS) begin
            char_count_in = char_count_ff + 8'd1;
            if (!zero_seen_ff) begin
               if (req_rx_byte == CHAR_NUL) begin
                  zero_seen_in = 1'b1;
               end else begin
                  if (char_count_ff == 8'd0) begin
                     lead_dollar_in = (req_rx_byte == CHAR_DOLLAR);
                  end
                  if (!star_seen_ff) begin
                     if (req_rx_byte == CHAR_STAR) begin
                        star_seen_in  = 1'b1;
                        star_early_in = (char_count_ff < 8'd2);
                        after_star_in = 2'd0;
                     end else if (char_count_ff != 8'd0) begin
                        xor_in = xor_ff ^ req_rx_byte;
                     end
                  end else if (after_star_ff < 2'd2) begin
                     hex_in[after_star_ff[0]] = req_rx_byte;
                     after_star_in = after_star_ff + 2'd1;
                  end
                  if (char_count_ff >= 8'd3 && char_count_ff <= 8'd5) begin
                     kind_in[2'(char_count_ff - 8'd3)] = req_rx_byte;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff  <= 8'd0;
         lead_dollar_ff <= 1'b0;
         zero_seen_ff   <= 1'b0;
         star_seen_ff   <= 1'b0;
         star_early_ff  <= 1'b0;
         xor_ff         <= 8'd0;
         hex_ff         <= '{8'd0, 8'd0};
         after_star_ff  <= 2'd0;
         kind_ff        <= '{8'd0, 8'd0, 8'd0};
      end else begin
         char_count_ff  <= char_count_in;
         lead_dollar_ff <= lead_dollar_in;
         zero_seen_ff   <= zero_seen_in;
         star_seen_ff   <= star_seen_in;
         star_early_ff  <= star_early_in;
         xor_ff         <= xor_in;
         hex_ff         <= hex_in;
         after_star_ff  <= after_star_in;
         kind_ff        <= kind_in;
      end
   end

endmodule

// File: design/nsc_queue.sv
// Short queue of finished lines between the front end and the counter stage.
// Depends on nsc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module nsc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  nsc_pkg::line_type push_line,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output nsc_pkg::line_type pop_line
);
   import nsc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   line_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == DEPTH_CNT);
   assign not_empty = (count_ff != '0);
   assign pop_line  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_line;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_NEVER(a_no_overflow, clock, reset, push && full)
   `ASSERT_NEVER(a_no_underflow, clock, reset, pop && !not_empty)
   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= DEPTH_CNT)

endmodule

// File: design/nsc_back.sv
// Back end: updates the line, error and kind counters and holds the result register.
// Depends on nsc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module nsc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              not_empty,
   input  nsc_pkg::line_type pop_line,
   output logic              pop,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic [7:0]        rsp_line_length,
   output logic [7:0]        rsp_computed_sum,
   output logic [7:0]        rsp_expected_sum,
   output logic [31:0]       rsp_total_lines,
   output logic [31:0]       rsp_error_total,
   output logic [31:0]       rsp_kind_total
);
   import nsc_pkg::*;

   logic [31:0] line_cnt_ff, line_cnt_in;
   logic [31:0] err_cnt_ff, err_cnt_in;
   logic [31:0] kind_cnt_ff [NUM_KINDS];
   logic [31:0] kind_cnt_in [NUM_KINDS];
   logic        valid_ff, valid_in;
   line_type    line_ff;
   logic [31:0] kind_total_ff, kind_total_in;

   // Take a line whenever the result register is free or being drained.
   assign pop = not_empty && (!valid_ff || !rsp_stall);

   always_comb begin
      line_cnt_in   = line_cnt_ff;
      err_cnt_in    = err_cnt_ff;
      kind_cnt_in   = kind_cnt_ff;
      kind_total_in = kind_total_ff;
      valid_in      = valid_ff && rsp_stall;
      if (pop) begin
         valid_in      = 1'b1;
         line_cnt_in   = line_cnt_ff + 32'd1;
         kind_total_in = 32'd0;
         if (pop_line.status == STATUS_CSUM_ERR) begin
            err_cnt_in = err_cnt_ff + 32'd1;
         end
         for (int k = 0; k < NUM_KINDS; k++) begin
            if (pop_line.status == KIND_STATUS[k]) begin
               kind_cnt_in[k] = kind_cnt_ff[k] + 32'd1;
               kind_total_in  = kind_cnt_ff[k] + 32'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         line_ff       <= pop_line;
         kind_total_ff <= kind_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         line_cnt_ff <= 32'd0;
         err_cnt_ff  <= 32'd0;
         for (int k = 0; k < NUM_KINDS; k++) begin
            kind_cnt_ff[k] <= 32'd0;
         end
      end else begin
         valid_ff    <= valid_in;
         line_cnt_ff <= line_cnt_in;
         err_cnt_ff  <= err_cnt_in;
         kind_cnt_ff <= kind_cnt_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = line_ff.status;
   assign rsp_line_length  = line_ff.line_length;
   assign rsp_computed_sum = line_ff.computed_sum;
   assign rsp_expected_sum = line_ff.expected_sum;
   assign rsp_total_lines  = line_cnt_ff;
   assign rsp_error_total  = err_cnt_ff;
   assign rsp_kind_total   = kind_total_ff;

   `ASSERT_CLK(a_pop_shows_result, clock, reset, pop |=> valid_ff)
   `ASSERT_CLK(a_line_count_step, clock, reset,
      pop |=> (line_cnt_ff == $past(line_cnt_ff) + 32'd1))
   `ASSERT_CLK(a_counts_hold_idle, clock, reset,
      !pop |=> ($stable(line_cnt_ff) && $stable(err_cnt_ff)))

endmodule
